// ===== design/ebct_pkg.sv =====
// ============================================================================
// ebct_pkg: shared definitions for the EEPROM byte cache tracker
// Holds the cache depth, request and status codes, entry layout and the
// sequencer state type.
// ============================================================================
package ebct_pkg;

    // Number of cached bytes (2 to 256).
    localparam int ENTRIES = 256;
    // Index width into the cache memory.
    localparam int AW = $clog2(ENTRIES);

    localparam int ADDR_W = 8;
    localparam int SIZE_W = 9;
    localparam int BYTE_W = 8;

    // Input stream layout.
    localparam int IN_TDATA_W = 32;
    localparam int IN_TUSER_W = 2;
    // Output stream layout.
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        REQ_HOST_RD   = 2'd0,
        REQ_HOST_WR   = 2'd1,
        REQ_SCAN      = 2'd2,
        REQ_XFER_DONE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_UNREAD  = 2'd0,
        ST_PENDING = 2'd1,
        ST_VALID   = 2'd2,
        ST_DIRTY   = 2'd3
    } t_status;

    typedef struct packed {
        t_status             st;
        logic [BYTE_W-1:0]   data;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SCHK
    } t_state;

endpackage

// ===== design/eeprom_byte_cache_tracker.sv =====
// ============================================================================
// eeprom_byte_cache_tracker: write-back byte cache status tracker
// Keeps a cached value and a 2-bit status for every byte of a small EEPROM,
// serves host reads and writes, scans ranges for bytes that still need a
// device transfer and records completed transfers.
// ============================================================================
//
// Channel   Direction  Handshake                 Contents
// s_axis    in         tvalid/tready             one request item
// m_axis    out        tvalid/tready             one result item per request
//
// Host read, host write, transfer-done and bad-range scan items pass through accept, memory
// read, then modify with write-back and output load. A good scan reads and examines its
// bytes one at a time from the start address until one needs a transfer or the range ends.
// The single-port memory with its registered read sets this sequence.
// Reset is synchronous and active low; a valid flop per entry makes unwritten bytes read as
// unread and zero. A result left in the output register stalls the next load and write-back.
//
module eeprom_byte_cache_tracker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Request stream.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata from bit 0: addr[7:0], size[16:8], data[24:17], is_write[25],
    // first[26], zero padding[31:27].
    input  logic [ebct_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser from bit 0: req_type[1:0].
    input  logic [ebct_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,
    // tlast: last.
    input  logic                             i_s_axis_tlast,
    // Result stream.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata from bit 0: byte_out[7:0], range_ready[8], write_needed[9],
    // found[10], next_address[18:11], range_error[19], zero padding[23:20].
    output logic [ebct_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // tlast: range_last.
    output logic                             o_m_axis_tlast
);
    import ebct_pkg::*;

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] s_in_addr;
    logic [SIZE_W-1:0] s_in_size;
    logic [BYTE_W-1:0] s_in_data;
    logic              s_in_is_write;
    logic              s_in_first;
    t_req              s_in_req;
    logic              s_accept;

    assign s_in_addr     = i_s_axis_tdata[7:0];
    assign s_in_size     = i_s_axis_tdata[16:8];
    assign s_in_data     = i_s_axis_tdata[24:17];
    assign s_in_is_write = i_s_axis_tdata[25];
    assign s_in_first    = i_s_axis_tdata[26];
    assign s_in_req      = t_req'(i_s_axis_tuser);

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    // Range checks, evaluated on the incoming item and registered.
    logic [SIZE_W:0] s_range_end;   // addr + size, one bit of headroom
    logic [SIZE_W:0] s_last_addr;   // addr + size - 1
    logic            s_in_range;
    logic            s_bad_range;

    assign s_range_end = {2'b00, s_in_addr} + {1'b0, s_in_size};
    assign s_last_addr = s_range_end - (SIZE_W+1)'(1);
    assign s_in_range  = ({1'b0, s_in_addr} < SIZE_W'(ENTRIES));
    assign s_bad_range = (s_in_size == '0) || (s_range_end > (SIZE_W+1)'(ENTRIES));

    // ------------------------------------------------------------------
    // Request registers
    // ------------------------------------------------------------------
    t_req              r_req;
    logic [BYTE_W-1:0] r_data;
    logic              r_is_write;
    logic              r_first;
    logic              r_last;
    logic              r_in_range;
    logic              r_err;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     r_end;

    // ------------------------------------------------------------------
    // Control and accumulated flags
    // ------------------------------------------------------------------
    t_state      r_state;
    t_state      n_state;
    logic        r_ready_acc;
    logic        n_ready_acc;
    logic        r_write_acc;
    logic        n_write_acc;
    logic        r_ovld;

    // ------------------------------------------------------------------
    // Cache memory: status and byte together, one entry per address.
    // r_vld marks entries written since reset.
    // ------------------------------------------------------------------
    t_entry             r_mem [ENTRIES];
    t_entry             r_mem_q;
    logic               r_vld_q;
    logic [ENTRIES-1:0] r_vld;
    t_entry             s_entry;

    assign s_entry = r_vld_q ? r_mem_q : t_entry'{st: ST_UNREAD, data: '0};

    // ------------------------------------------------------------------
    // Datapath signals
    // ------------------------------------------------------------------
    logic              s_can_out;
    logic              s_need;
    logic              s_scan_end;
    logic              s_we;
    t_entry            n_entry;
    logic              s_load_out;
    logic              s_idx_inc;
    logic [BYTE_W-1:0] n_byte_out;
    logic              n_found;
    logic [ADDR_W-1:0] n_next_addr;
    logic              n_err;

    logic [BYTE_W-1:0] r_byte_out;
    logic              r_o_ready;
    logic              r_o_write;
    logic              r_found;
    logic [ADDR_W-1:0] r_next_addr;
    logic              r_o_err;
    logic              r_o_last;

    // The output register can take a new result if it is empty or its
    // current result is being taken in this cycle.
    assign s_can_out = !r_ovld || i_m_axis_tready;

    // A read scan leaves dirty bytes alone; a write scan reports them.
    assign s_need = (s_entry.st == ST_UNREAD) || (s_entry.st == ST_PENDING) ||
                    ((s_entry.st == ST_DIRTY) && r_is_write);
    assign s_scan_end = (r_idx == r_end);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if ((r_req == REQ_SCAN) && !r_err) begin
                    n_state = S_SCHK;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (s_can_out) begin
                    n_state = S_IDLE;
                end
            end
            S_SCHK: begin
                if (s_need || s_scan_end) begin
                    if (s_can_out) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer: write-back, flag update and result.
    // ------------------------------------------------------------------
    always_comb begin
        logic ready_base;
        logic write_base;

        ready_base = r_ready_acc;
        write_base = r_write_acc;
        if (r_first && ((r_req == REQ_HOST_RD) || (r_req == REQ_HOST_WR))) begin
            ready_base = 1'b1;
            write_base = 1'b0;
        end

        s_we        = 1'b0;
        n_entry     = s_entry;
        s_load_out  = 1'b0;
        s_idx_inc   = 1'b0;
        n_ready_acc = r_ready_acc;
        n_write_acc = r_write_acc;
        n_byte_out  = '0;
        n_found     = 1'b0;
        n_next_addr = '0;
        n_err       = 1'b0;

        case (r_state)
            S_EXEC: begin
                n_ready_acc = ready_base;
                n_write_acc = write_base;
                case (r_req)
                    REQ_HOST_RD: begin
                        if (r_in_range) begin
                            n_byte_out = s_entry.data;
                            if (s_entry.st == ST_UNREAD) begin
                                n_entry.st  = ST_PENDING;
                                s_we        = 1'b1;
                                n_ready_acc = 1'b0;
                            end else if (s_entry.st == ST_PENDING) begin
                                n_ready_acc = 1'b0;
                            end
                        end
                    end
                    REQ_HOST_WR: begin
                        // An unchanged byte that is already valid needs no write.
                        if (r_in_range &&
                            !((s_entry.st == ST_VALID) && (s_entry.data == r_data))) begin
                            n_entry.st   = ST_DIRTY;
                            n_entry.data = r_data;
                            s_we         = 1'b1;
                            n_write_acc  = 1'b1;
                        end
                    end
                    REQ_SCAN: begin
                        // Only a bad range reaches this state.
                        n_err = 1'b1;
                    end
                    REQ_XFER_DONE: begin
                        if (r_in_range) begin
                            n_entry.st = ST_VALID;
                            if (!r_is_write) begin
                                n_entry.data = r_data;
                            end
                            s_we = 1'b1;
                        end
                    end
                    default: begin
                        n_err = 1'b0;
                    end
                endcase
                // Nothing commits until the result can be stored.
                if (!s_can_out) begin
                    s_we        = 1'b0;
                    n_ready_acc = r_ready_acc;
                    n_write_acc = r_write_acc;
                end
                s_load_out = s_can_out;
            end
            S_SCHK: begin
                if (s_need) begin
                    n_found     = 1'b1;
                    n_next_addr = ADDR_W'(r_idx);
                    n_byte_out  = r_is_write ? s_entry.data : '0;
                    s_load_out  = s_can_out;
                end else if (s_scan_end) begin
                    s_load_out = s_can_out;
                end else begin
                    s_idx_inc = 1'b1;
                end
            end
            default: begin
                s_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready_acc <= 1'b1;
            r_write_acc <= 1'b0;
            r_ovld      <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_ready_acc <= n_ready_acc;
            r_write_acc <= n_write_acc;
            if (s_load_out) begin
                r_ovld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovld <= 1'b0;
            end
            if (s_we) begin
                r_vld[r_idx] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request registers and scan index
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req      <= s_in_req;
            r_data     <= s_in_data;
            r_is_write <= s_in_is_write;
            r_first    <= s_in_first;
            r_last     <= i_s_axis_tlast;
            r_in_range <= s_in_range;
            r_err      <= s_bad_range;
            r_idx      <= s_in_addr[AW-1:0];
            r_end      <= s_last_addr[AW-1:0];
        end else if (s_idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Cache memory ports
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem[r_idx] <= n_entry;
        end
        if (r_state == S_READ) begin
            r_mem_q <= r_mem[r_idx];
            r_vld_q <= r_vld[r_idx];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_load_out) begin
            r_byte_out  <= n_byte_out;
            r_o_ready   <= n_ready_acc;
            r_o_write   <= n_write_acc;
            r_found     <= n_found;
            r_next_addr <= n_next_addr;
            r_o_err     <= n_err;
            r_o_last    <= r_last;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = {4'b0000, r_o_err, r_next_addr, r_found,
                              r_o_write, r_o_ready, r_byte_out};
    assign o_m_axis_tlast  = r_o_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCHK) |-> !s_we)
        else $error("cache memory written during a scan");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_load_out |-> (!r_ovld || i_m_axis_tready))
        else $error("result loaded over an untaken result");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_READ))
        else $error("accepted item did not start a memory read");

    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCHK) |-> (r_idx <= r_end))
        else $error("scan index ran past the end of its range");

    a_write_commits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_we |-> s_load_out)
        else $error("memory written without producing a result");

endmodule

// ===== tb/sv/tb_eeprom_byte_cache_tracker.sv =====
// ============================================================================
// tb_eeprom_byte_cache_tracker: self-checking bench for the byte cache tracker
// A mirror of the cache contents and per-byte status predicts every response.
// Directed requests come first, then randomized host ranges followed by scan
// and transfer-done servicing, mixed with unstructured noise. The sender and
// receiver throttle at random in three backpressure phases.
// ============================================================================
module tb_eeprom_byte_cache_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    import ebct_pkg::*;

    // Cycles without any handshake, while work is outstanding, before giving up.
    // The slowest legal request is a full-depth scan.
    localparam int unsigned STALL_LIMIT = 20000;
    // Quiet cycles after the last response, to catch stray extra responses.
    localparam int unsigned DRAIN_CYCLES = 40;
    // Cap on printed mismatch lines; every mismatch is still counted.
    localparam int unsigned MAX_REPORTS = 100;

    typedef struct packed {
        t_req              req;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [BYTE_W-1:0] data;
        logic              is_write;
        logic              first;
        logic              last;
    } t_cache_req;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              range_ready;
        logic              write_needed;
        logic              found;
        logic [ADDR_W-1:0] next_address;
        logic              range_error;
        logic              range_last;
    } t_cache_resp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [IN_TUSER_W-1:0]  s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    // Mirror of the cache: byte values, per-byte status and the range flags.
    logic [BYTE_W-1:0] mirror_bytes [ENTRIES];
    t_status           mirror_status [ENTRIES];
    logic              mirror_ready;
    logic              mirror_write;

    // Responses predicted at request acceptance, oldest first.
    t_cache_resp pending_responses [$];

    int unsigned src_idle_pct;
    int unsigned dst_idle_pct;
    int unsigned mismatches;
    int unsigned reported;
    int unsigned n_checked;
    int unsigned n_reads, n_writes, n_scans, n_hits, n_bad_ranges, n_xfers;
    logic        timed_out;

    eeprom_byte_cache_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver throttling: ready is redrawn every cycle at the falling edge.
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Prediction: applies one request to the mirror and returns the response.
    // ------------------------------------------------------------------------
    function automatic t_cache_resp predict_cache_response(input t_cache_req rq);
        t_cache_resp rs;
        t_status     st;
        int unsigned a;
        rs = '0;
        // A first flag on a host byte restarts the range flags before the byte.
        if ((rq.req == REQ_HOST_RD || rq.req == REQ_HOST_WR) && rq.first) begin
            mirror_ready = 1'b1;
            mirror_write = 1'b0;
        end
        case (rq.req)
            REQ_HOST_RD: begin
                n_reads++;
                if (rq.addr < ENTRIES) begin
                    st = mirror_status[rq.addr];
                    if (st == ST_UNREAD) begin
                        mirror_status[rq.addr] = ST_PENDING;
                        mirror_ready = 1'b0;
                    end else if (st == ST_PENDING) begin
                        mirror_ready = 1'b0;
                    end
                    rs.byte_out = mirror_bytes[rq.addr];
                end
            end
            REQ_HOST_WR: begin
                n_writes++;
                if (rq.addr < ENTRIES) begin
                    // Rewriting a valid byte with its own value costs nothing.
                    if (!(mirror_status[rq.addr] == ST_VALID &&
                          mirror_bytes[rq.addr] == rq.data)) begin
                        mirror_bytes[rq.addr] = rq.data;
                        mirror_status[rq.addr] = ST_DIRTY;
                        mirror_write = 1'b1;
                    end
                end
            end
            REQ_SCAN: begin
                n_scans++;
                if (rq.size == 0 || int'(rq.addr) + int'(rq.size) > ENTRIES) begin
                    rs.range_error = 1'b1;
                    n_bad_ranges++;
                end else begin
                    // Dirty bytes only need a transfer when writing back.
                    for (a = rq.addr; a < int'(rq.addr) + int'(rq.size); a++) begin
                        st = mirror_status[a];
                        if (st == ST_UNREAD || st == ST_PENDING ||
                            (st == ST_DIRTY && rq.is_write)) begin
                            rs.found = 1'b1;
                            rs.next_address = a[ADDR_W-1:0];
                            rs.byte_out = rq.is_write ? mirror_bytes[a] : '0;
                            n_hits++;
                            break;
                        end
                    end
                end
            end
            default: begin
                n_xfers++;
                if (rq.addr < ENTRIES) begin
                    // A completed write leaves the cached byte alone.
                    if (!rq.is_write) begin
                        mirror_bytes[rq.addr] = rq.data;
                    end
                    mirror_status[rq.addr] = ST_VALID;
                end
            end
        endcase
        rs.range_ready  = mirror_ready;
        rs.write_needed = mirror_write;
        rs.range_last   = rq.last;
        return rs;
    endfunction

    function automatic t_cache_req make_req(input t_req req, input int unsigned addr,
                                            input int unsigned size,
                                            input int unsigned data, input logic is_write,
                                            input logic first, input logic last);
        t_cache_req rq;
        rq.req      = req;
        rq.addr     = addr[ADDR_W-1:0];
        rq.size     = size[SIZE_W-1:0];
        rq.data     = data[BYTE_W-1:0];
        rq.is_write = is_write;
        rq.first    = first;
        rq.last     = last;
        return rq;
    endfunction

    // Random single bit.
    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    // ------------------------------------------------------------------------
    // Sends one request item. Valid stays high between back-to-back items;
    // idle cycles are inserted before the item at the sender's idle rate.
    // The predicted response is returned so sequences can react to it.
    // ------------------------------------------------------------------------
    task automatic send_request(input t_cache_req rq, output t_cache_resp rs);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, rq.first, rq.is_write, rq.data, rq.size, rq.addr};
        s_tuser  <= rq.req;
        s_tlast  <= rq.last;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        rs = predict_cache_response(rq);
        pending_responses.push_back(rs);
    endtask

    // ------------------------------------------------------------------------
    // Response checker: every accepted result is matched against the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (reported < MAX_REPORTS) begin
                reported++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin : check_responses
        t_cache_resp want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_responses.size() == 0) begin
                check_field("unexpected response", 0, 1);
            end else begin
                want = pending_responses.pop_front();
                n_checked++;
                check_field("byte_out", want.byte_out, m_tdata[7:0]);
                check_field("range_ready", want.range_ready, m_tdata[8]);
                check_field("write_needed", want.write_needed, m_tdata[9]);
                check_field("found", want.found, m_tdata[10]);
                check_field("next_address", want.next_address, m_tdata[18:11]);
                check_field("range_error", want.range_error, m_tdata[19]);
                check_field("range_last", want.range_last, m_tlast);
            end
        end
    end

    // Returns only if the block stops making progress while work is pending.
    task automatic watch_progress();
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else if (s_tvalid || pending_responses.size() != 0) begin
                quiet++;
            end
        end
        timed_out = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Reads of unread bytes at both ends mark them pending and drop ready.
    task automatic test_host_reads();
        t_cache_resp rs;
        send_request(make_req(REQ_HOST_RD, 0, 0, 0, 1'b0, 1'b1, 1'b0), rs);
        send_request(make_req(REQ_HOST_RD, ENTRIES - 1, 511, 255, 1'b1, 1'b0, 1'b1), rs);
        // A pending byte still holds ready low after a fresh range start.
        send_request(make_req(REQ_HOST_RD, ENTRIES - 1, 0, 0, 1'b0, 1'b1, 1'b1), rs);
    endtask

    // Range limits: single bytes, empty, overflowing and exactly full ranges.
    task automatic test_scans();
        t_cache_resp rs;
        send_request(make_req(REQ_SCAN, 0, 1, 0, 1'b0, 1'b0, 1'b0), rs);
        send_request(make_req(REQ_SCAN, ENTRIES - 1, 1, 255, 1'b1, 1'b1, 1'b1), rs);
        send_request(make_req(REQ_SCAN, 7, 0, 0, 1'b0, 1'b0, 1'b0), rs);
        send_request(make_req(REQ_SCAN, 1, ENTRIES, 0, 1'b0, 1'b0, 1'b1), rs);
        send_request(make_req(REQ_SCAN, 0, ENTRIES, 0, 1'b1, 1'b0, 1'b0), rs);
        send_request(make_req(REQ_SCAN, 0, 511, 0, 1'b0, 1'b0, 1'b0), rs);
        send_request(make_req(REQ_SCAN, ENTRIES / 2, ENTRIES / 2, 0, 1'b0, 1'b0, 1'b0), rs);
    endtask

    // Completions fill bytes from the device; a write completion keeps the byte.
    task automatic test_transfer_completion();
        t_cache_resp rs;
        send_request(make_req(REQ_XFER_DONE, 0, 0, 'hA5, 1'b0, 1'b0, 1'b0), rs);
        send_request(make_req(REQ_XFER_DONE, ENTRIES - 1, 0, 'hFF, 1'b0, 1'b1, 1'b1), rs);
        send_request(make_req(REQ_HOST_RD, 0, 0, 0, 1'b0, 1'b1, 1'b1), rs);
        send_request(make_req(REQ_XFER_DONE, ENTRIES / 2, 0, 'h5A, 1'b1, 1'b0, 1'b0), rs);
    endtask

    // Writes: unchanged valid byte skipped, dirty handling in reads and scans,
    // and a write completion after the host changed the byte.
    task automatic test_host_writes();
        t_cache_resp rs;
        send_request(make_req(REQ_HOST_WR, 0, 0, 'hA5, 1'b0, 1'b1, 1'b0), rs);
        send_request(make_req(REQ_HOST_WR, 0, 0, 'h5A, 1'b0, 1'b0, 1'b1), rs);
        send_request(make_req(REQ_HOST_RD, 0, 0, 0, 1'b0, 1'b1, 1'b1), rs);
        send_request(make_req(REQ_SCAN, 0, 2, 0, 1'b0, 1'b0, 1'b0), rs);
        send_request(make_req(REQ_SCAN, 0, 1, 0, 1'b1, 1'b0, 1'b0), rs);
        send_request(make_req(REQ_XFER_DONE, 0, 0, 'h33, 1'b1, 1'b0, 1'b0), rs);
        send_request(make_req(REQ_HOST_RD, 0, 0, 0, 1'b0, 1'b1, 1'b1), rs);
        send_request(make_req(REQ_HOST_WR, ENTRIES / 2, 0, 0, 1'b0, 1'b1, 1'b1), rs);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic. Most of it is whole host ranges followed by servicing:
    // scan the range, complete the byte the scan points at, and repeat until
    // nothing is left. The rest is unstructured noise.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic(input int unsigned n_items);
        t_cache_req  rq;
        t_cache_resp rs;
        int unsigned sent, len, base, k, wdata, scan_size;
        logic        wr;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 75) begin
                wr = rand_bit();
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
                base = $urandom_range(ENTRIES - len);
                for (k = 0; k < len; k++) begin
                    // Half the writes repeat the cached value to hit the skip path.
                    wdata = $urandom_range(1) ? mirror_bytes[base + k] : $urandom_range(255);
                    rq = make_req(wr ? REQ_HOST_WR : REQ_HOST_RD, base + k,
                                  $urandom_range(511), wdata, rand_bit(),
                                  k == 0, k == len - 1);
                    send_request(rq, rs);
                    sent++;
                end
                for (k = 0; k <= len; k++) begin
                    rq = make_req(REQ_SCAN, base, len, $urandom_range(255), wr,
                                  rand_bit(), rand_bit());
                    send_request(rq, rs);
                    sent++;
                    if (!rs.found || $urandom_range(19) == 0) begin
                        break;
                    end
                    rq = make_req(REQ_XFER_DONE, rs.next_address, $urandom_range(511),
                                  $urandom_range(255), wr, rand_bit(), rand_bit());
                    send_request(rq, rs);
                    sent++;
                end
            end else begin
                // Keep most noise scans short; full-depth scans are slow.
                scan_size = ($urandom_range(4) == 0) ? $urandom_range(511)
                                                     : $urandom_range(1, 16);
                rq = make_req(t_req'($urandom_range(3)), $urandom_range(255), scan_size,
                              $urandom_range(255), rand_bit(), rand_bit(), rand_bit());
                send_request(rq, rs);
                sent++;
            end
        end
    endtask

    task automatic run_all_tests();
        src_idle_pct = 36;
        dst_idle_pct = 81;
        test_host_reads();
        test_scans();
        test_transfer_completion();
        test_host_writes();
        test_random_traffic(700);
        src_idle_pct = 81;
        dst_idle_pct = 36;
        test_random_traffic(700);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        test_random_traffic(600);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_responses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            mirror_bytes[i]  = '0;
            mirror_status[i] = ST_UNREAD;
        end
        mirror_ready = 1'b1;
        mirror_write = 1'b0;
        mismatches = 0;
        reported = 0;
        n_checked = 0;
        n_reads = 0;
        n_writes = 0;
        n_scans = 0;
        n_hits = 0;
        n_bad_ranges = 0;
        n_xfers = 0;
        timed_out = 1'b0;
        src_idle_pct = 0;
        dst_idle_pct = 0;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_HOST_RD;
        s_tlast  = 1'b0;
        m_tready = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        fork
            run_all_tests();
            watch_progress();
        join_any

        $display("Checked %0d responses: %0d host reads, %0d host writes, %0d transfer completions,",
                 n_checked, n_reads, n_writes, n_xfers);
        $display("and %0d scans (%0d found a byte, %0d bad ranges); %0d mismatches.",
                 n_scans, n_hits, n_bad_ranges, mismatches);
        if (!timed_out && mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ebct_pkg.sv
design/eeprom_byte_cache_tracker.sv
tb/sv/tb_eeprom_byte_cache_tracker.sv
